### src/assert_macros.svh
// assertion helper macros shared by the rtl files
// depends on a clock named clk and a reset named rst in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/wdfc_pkg.sv
// shared types and constants for the wave data frame counter
// no dependencies
package wdfc_pkg;

  localparam int DIV_STEPS = 32;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
  localparam logic [2:0] ST_BAD_WAVE  = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_NO_ALIGN  = 3'd4;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;

  localparam logic [4:0] FMT_MIN_LEN = 5'd16;
  localparam logic [4:0] FMT_ALIGN_LO = 5'd12;
  localparam logic [4:0] FMT_ALIGN_HI = 5'd13;
  localparam logic [4:0] FIELD_LEN = 5'd4;

  // one unit of work handed from the parser to the divider side
  typedef struct packed {
    logic        is_div;
    logic [31:0] length;
    logic [15:0] align;
    logic [2:0]  status;
  } job_t;

endpackage

### src/wdfc_front.sv
// byte parser: walks the riff chunks and produces one job per file
// depends on wdfc_pkg
module wdfc_front
  import wdfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_xfer,
  input  logic [7:0] file_byte,
  input  logic       end_of_file,
  output logic       job_push,
  output job_t       job
);

  localparam logic [2:0] PH_RIFF_TAG   = 3'd0;
  localparam logic [2:0] PH_RIFF_SIZE  = 3'd1;
  localparam logic [2:0] PH_WAVE_TAG   = 3'd2;
  localparam logic [2:0] PH_CHUNK_ID   = 3'd3;
  localparam logic [2:0] PH_CHUNK_SIZE = 3'd4;
  localparam logic [2:0] PH_FMT_BODY   = 3'd5;
  localparam logic [2:0] PH_SKIP       = 3'd6;
  localparam logic [2:0] PH_DONE       = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [4:0]  index, index_next;
  logic [31:0] tag, tag_next;
  logic [31:0] length, length_next;
  logic [32:0] skip, skip_next;
  logic [15:0] align, align_next;
  logic        answered, answered_next;

  logic [4:0]  index_inc;
  logic [31:0] length_acc;
  logic [32:0] skip_dec;
  logic        do_skip;
  logic [32:0] skip_amt;
  logic        emit;
  logic        emit_div;
  logic [2:0]  emit_status;

  assign index_inc  = index + 5'd1;
  // size is little-endian
  assign length_acc = length | ({24'd0, file_byte} << {index[1:0], 3'd0});
  assign skip_dec   = (skip != 33'd0) ? skip - 33'd1 : skip;

  always_comb begin
    phase_next    = phase;
    index_next    = index;
    tag_next      = tag;
    length_next   = length;
    skip_next     = skip;
    align_next    = align;
    answered_next = answered;
    do_skip       = 1'b0;
    skip_amt      = 33'd0;
    emit          = 1'b0;
    emit_div      = 1'b0;
    emit_status   = ST_OK;

    unique case (phase) inside
      PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
        tag_next   = {tag[23:0], file_byte};
        index_next = index_inc;
        if (index_inc >= FIELD_LEN) begin
          index_next = 5'd0;
          if (phase == PH_RIFF_TAG) begin
            if (tag_next != TAG_RIFF) begin
              emit        = 1'b1;
              emit_status = ST_BAD_RIFF;
            end else begin
              phase_next = PH_RIFF_SIZE;
            end
          end else if (phase == PH_WAVE_TAG) begin
            if (tag_next != TAG_WAVE) begin
              emit        = 1'b1;
              emit_status = ST_BAD_WAVE;
            end else begin
              phase_next = PH_CHUNK_ID;
            end
          end else begin
            length_next = 32'd0;
            phase_next  = PH_CHUNK_SIZE;
          end
        end
      end
      PH_RIFF_SIZE: begin
        index_next = index_inc;
        if (index_inc >= FIELD_LEN) begin
          index_next = 5'd0;
          phase_next = PH_WAVE_TAG;
        end
      end
      PH_CHUNK_SIZE: begin
        length_next = length_acc;
        index_next  = index_inc;
        if (index_inc >= FIELD_LEN) begin
          index_next = 5'd0;
          if (tag == TAG_DATA) begin
            emit = 1'b1;
            if (align == 16'd0) begin
              emit_status = ST_NO_ALIGN;
            end else begin
              emit_div = 1'b1;
            end
          end else if (tag == TAG_FMT) begin
            align_next = 16'd0;
            if (length_next >= {27'd0, FMT_MIN_LEN}) begin
              phase_next = PH_FMT_BODY;
            end else begin
              do_skip  = 1'b1;
              skip_amt = {1'b0, length_next} + {32'd0, length_next[0]};
            end
          end else begin
            do_skip  = 1'b1;
            skip_amt = {1'b0, length_next} + {32'd0, length_next[0]};
          end
        end
      end
      PH_FMT_BODY: begin
        if (index == FMT_ALIGN_LO) begin
          align_next[7:0] = file_byte;
        end else if (index == FMT_ALIGN_HI) begin
          align_next[15:8] = file_byte;
        end
        index_next = index_inc;
        if (index_inc >= FMT_MIN_LEN) begin
          // rest of the body after the first sixteen bytes, plus pad
          do_skip  = 1'b1;
          skip_amt = {1'b0, length - {27'd0, FMT_MIN_LEN}} + {32'd0, length[0]};
        end
      end
      PH_SKIP: begin
        skip_next = skip_dec;
        if (skip_dec == 33'd0) begin
          phase_next = PH_CHUNK_ID;
          index_next = 5'd0;
        end
      end
      default: begin
      end
    endcase

    if (do_skip) begin
      skip_next  = skip_amt;
      phase_next = (skip_amt != 33'd0) ? PH_SKIP : PH_CHUNK_ID;
      index_next = 5'd0;
    end

    if (emit) begin
      answered_next = 1'b1;
      phase_next    = PH_DONE;
    end

    if (end_of_file) begin
      if (!answered_next) begin
        emit        = 1'b1;
        emit_div    = 1'b0;
        emit_status = ST_TRUNCATED;
      end
      phase_next    = PH_RIFF_TAG;
      index_next    = 5'd0;
      tag_next      = 32'd0;
      length_next   = 32'd0;
      skip_next     = 33'd0;
      align_next    = 16'd0;
      answered_next = 1'b0;
    end
  end

  assign job_push    = in_xfer && emit;
  assign job.is_div  = emit_div;
  assign job.length  = length_acc;
  assign job.align   = align;
  assign job.status  = emit_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_RIFF_TAG;
      index    <= 5'd0;
      tag      <= 32'd0;
      length   <= 32'd0;
      skip     <= 33'd0;
      align    <= 16'd0;
      answered <= 1'b0;
    end else if (in_xfer) begin
      phase    <= phase_next;
      index    <= index_next;
      tag      <= tag_next;
      length   <= length_next;
      skip     <= skip_next;
      align    <= align_next;
      answered <= answered_next;
    end
  end

endmodule

### src/wdfc_queue.sv
// short job queue between the parser and the divider side
// depends on wdfc_pkg and assert_macros.svh
`include "assert_macros.svh"
module wdfc_queue
  import wdfc_pkg::*;
#(
  parameter int DEPTH = 2
)(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= FULL_CNT, "queue count beyond depth")
  `ASSERT_NEXT(a_push_grows, do_push && !do_pop, count == $past(count) + CNT_W'(1), "push lost")
  `ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, count == $past(count) - CNT_W'(1), "pop lost")

endmodule

### src/wdfc_back.sv
// divider side: one quotient bit a cycle, then a one-entry result register
// depends on wdfc_pkg and assert_macros.svh
`include "assert_macros.svh"
module wdfc_back
  import wdfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_take,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] frame_count,
  output logic [2:0]  status
);

  localparam logic [4:0] LAST_STEP = 5'(DIV_STEPS - 1);

  logic        busy;
  logic        out_valid;
  logic [4:0]  step;
  logic [31:0] quot;
  logic [15:0] rem;
  logic [15:0] divisor;
  logic [2:0]  out_status;

  logic [16:0] trial;
  logic [16:0] diff;
  logic        fits;

  assign job_take = job_valid && !busy && !out_valid;
  assign trial    = {rem, quot[31]};
  assign diff     = trial - {1'b0, divisor};
  assign fits     = (trial >= {1'b0, divisor});

  assign empty       = !out_valid;
  assign frame_count = quot;
  assign status      = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      step      <= 5'd0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (job_take) begin
        if (job.is_div) begin
          busy <= 1'b1;
          step <= 5'd0;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == LAST_STEP) begin
          busy      <= 1'b0;
          out_valid <= 1'b1;
        end
      end
    end
  end

  // restoring division, quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (job_take) begin
      quot       <= job.is_div ? job.length : 32'd0;
      rem        <= 16'd0;
      divisor    <= job.align;
      out_status <= job.status;
    end else if (busy) begin
      rem  <= fits ? diff[15:0] : trial[15:0];
      quot <= {quot[30:0], fits};
    end
  end

  `ASSERT_ALWAYS(a_busy_no_result, !(busy && out_valid), "result shown mid division")
  `ASSERT_NEXT(a_div_starts, job_take && job.is_div, busy && empty, "division did not start")
  `ASSERT_NEXT(a_div_ends, busy && step == LAST_STEP, !empty && status == ST_OK,
    "division did not finish")

endmodule

### src/wav_data_frame_counter.sv
// top level of the wave data frame counter: parser, job queue, divider side
// depends on wdfc_pkg, wdfc_front, wdfc_queue, wdfc_back
//
//   channel   direction  handshake     payload
//   input     in         push / full   file_byte, end_of_file
//   result    out        empty / pop   frame_count, status
//
// the parser takes one byte per cycle while the job queue has room
// a data chunk result with a nonzero align goes through the shift-subtract divider after its
// last size byte; error results skip the division and go straight to the result register
// full rises only when the job queue is full, which needs several files
// ended in quick succession while a result waits to be popped or a division runs
// rst is synchronous and returns the parser to the start of a file
module wav_data_frame_counter
  import wdfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] frame_count,
  output logic [2:0]  status
);

  logic in_xfer;
  logic job_push;
  job_t job_in;
  logic q_empty;
  job_t job_out;
  logic job_take;

  assign in_xfer = push && !full;

  wdfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_xfer     (in_xfer),
    .file_byte   (file_byte),
    .end_of_file (end_of_file),
    .job_push    (job_push),
    .job         (job_in)
  );

  wdfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job_in),
    .full     (full),
    .pop      (job_take),
    .empty    (q_empty),
    .pop_job  (job_out)
  );

  wdfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (!q_empty),
    .job         (job_out),
    .job_take    (job_take),
    .pop         (pop),
    .empty       (empty),
    .frame_count (frame_count),
    .status      (status)
  );

endmodule

### bench/wav_data_frame_counter_tb.sv
// testbench for wav_data_frame_counter: streams riff/wave byte files through the parser
// depends on wdfc_pkg and the wav_data_frame_counter rtl; a scoreboard predicts each result
module wav_data_frame_counter_tb;
  import wdfc_pkg::*;

  localparam int QUIET_LIMIT    = 3000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES    = 80;

  typedef enum logic [3:0] {
    WALK_RIFF_TAG,
    WALK_RIFF_SIZE,
    WALK_WAVE_TAG,
    WALK_CHUNK_ID,
    WALK_CHUNK_SIZE,
    WALK_FMT_BODY,
    WALK_SKIP,
    WALK_DONE
  } walk_phase_t;

  typedef struct {
    logic [31:0] frames;
    logic [2:0]  status;
  } frame_result_t;

  class frame_count_board;
    walk_phase_t   phase;
    logic [4:0]    field_idx;
    logic [31:0]   tag_bytes;
    logic [31:0]   chunk_len;
    logic [32:0]   skip_left;
    logic [15:0]   block_align;
    bit            answered;
    frame_result_t expected_counts[$];
    int            mismatches;

    function new();
      mismatches = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      phase       = WALK_RIFF_TAG;
      field_idx   = '0;
      tag_bytes   = '0;
      chunk_len   = '0;
      skip_left   = '0;
      block_align = '0;
      answered    = 1'b0;
    endfunction

    function void give_result(logic [31:0] frames, logic [2:0] st);
      frame_result_t r;
      r.frames = frames;
      r.status = st;
      expected_counts.push_back(r);
      answered = 1'b1;
      phase = WALK_DONE;
    endfunction

    function void start_skip(logic [32:0] amount);
      skip_left = amount;
      phase = (amount != 0) ? WALK_SKIP : WALK_CHUNK_ID;
      field_idx = '0;
    endfunction

    // one accepted byte of the file
    function void note_byte(logic [7:0] b, logic eof);
      case (phase)
        WALK_RIFF_TAG, WALK_WAVE_TAG, WALK_CHUNK_ID: begin
          tag_bytes = {tag_bytes[23:0], b};
          field_idx++;
          if (field_idx >= FIELD_LEN) begin
            field_idx = '0;
            if (phase == WALK_RIFF_TAG) begin
              if (tag_bytes != TAG_RIFF) give_result('0, ST_BAD_RIFF);
              else phase = WALK_RIFF_SIZE;
            end else if (phase == WALK_WAVE_TAG) begin
              if (tag_bytes != TAG_WAVE) give_result('0, ST_BAD_WAVE);
              else phase = WALK_CHUNK_ID;
            end else begin
              chunk_len = '0;
              phase = WALK_CHUNK_SIZE;
            end
          end
        end
        WALK_RIFF_SIZE: begin
          field_idx++;
          if (field_idx >= FIELD_LEN) begin
            field_idx = '0;
            phase = WALK_WAVE_TAG;
          end
        end
        WALK_CHUNK_SIZE: begin
          // size is little-endian
          chunk_len |= {24'd0, b} << (8 * field_idx[1:0]);
          field_idx++;
          if (field_idx >= FIELD_LEN) begin
            field_idx = '0;
            if (tag_bytes == TAG_DATA) begin
              if (block_align == 0) give_result('0, ST_NO_ALIGN);
              else give_result(chunk_len / {16'd0, block_align}, ST_OK);
            end else if (tag_bytes == TAG_FMT) begin
              block_align = '0;
              if (chunk_len >= 32'(FMT_MIN_LEN)) phase = WALK_FMT_BODY;
              else start_skip({1'b0, chunk_len} + chunk_len[0]);
            end else begin
              start_skip({1'b0, chunk_len} + chunk_len[0]);
            end
          end
        end
        WALK_FMT_BODY: begin
          if (field_idx == FMT_ALIGN_LO) block_align[7:0] = b;
          else if (field_idx == FMT_ALIGN_HI) block_align[15:8] = b;
          field_idx++;
          if (field_idx >= FMT_MIN_LEN)
            start_skip({1'b0, chunk_len - 32'(FMT_MIN_LEN)} + chunk_len[0]);
        end
        WALK_SKIP: begin
          if (skip_left != 0) skip_left--;
          if (skip_left == 0) begin
            phase = WALK_CHUNK_ID;
            field_idx = '0;
          end
        end
        default: ;
      endcase
      if (eof) begin
        if (!answered) give_result('0, ST_TRUNCATED);
        clear_walk();
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [31:0] frames, logic [2:0] st);
      frame_result_t want;
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("result %0d status %0d with none expected", frames, st));
      end else begin
        want = expected_counts.pop_front();
        if (frames !== want.frames)
          report_mismatch($sformatf("frame_count %0d, expected %0d", frames, want.frames));
        if (st !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
      end
    endtask

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  file_byte = '0;
  logic        end_of_file = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] frame_count;
  logic [2:0]  status;

  frame_count_board board;
  logic [7:0]  file_q[$];
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_request = 1'b0;
  bit          rx_holding = 1'b0;
  int          bytes_sent = 0;
  int          files_sent = 0;
  int          quiet_cycles = 0;

  wav_data_frame_counter u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .file_byte   (file_byte),
    .end_of_file (end_of_file),
    .empty       (empty),
    .pop         (pop),
    .frame_count (frame_count),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // file assembly into file_q
  function void put_random(int n);
    for (int i = 0; i < n; i++) file_q.push_back(8'($urandom));
  endfunction

  function void put_tag(logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_q.push_back(v[8*i +: 8]);
  endfunction

  function void put_le32(logic [31:0] v);
    for (int i = 0; i < 4; i++) file_q.push_back(v[8*i +: 8]);
  endfunction

  function void put_header();
    put_tag(TAG_RIFF);
    put_le32($urandom);
    put_tag(TAG_WAVE);
  endfunction

  // huge chunks get only part of their body, the file then ends inside them
  function void put_fmt(logic [31:0] len, logic [15:0] align);
    int body;
    body = (len <= 24) ? int'(len) : 16;
    put_tag(TAG_FMT);
    put_le32(len);
    for (int i = 0; i < body; i++)
      file_q.push_back(i == 12 ? align[7:0] : i == 13 ? align[15:8] : 8'($urandom));
    if (len <= 24 && len[0]) put_random(1);
  endfunction

  function void put_chunk(logic [31:0] tag, logic [31:0] len);
    int body;
    body = (len <= 24) ? int'(len) : 16;
    put_tag(tag);
    put_le32(len);
    put_random(body);
    if (len <= 24 && len[0]) put_random(1);
  endfunction

  function void put_data(logic [31:0] size);
    put_tag(TAG_DATA);
    put_le32(size);
  endfunction

  function void trim_file(int n);
    repeat (n) void'(file_q.pop_back());
  endfunction

  function void put_good_file();
    int          n_other;
    int          fmt_at;
    bit          with_fmt;
    logic [31:0] fmt_len;
    logic [15:0] align;
    logic [31:0] other_tag;
    logic [31:0] size;
    n_other = $urandom_range(0, 2);
    fmt_at = $urandom_range(0, n_other);
    with_fmt = $urandom_range(0, 9) < 8;
    put_header();
    for (int i = 0; i <= n_other; i++) begin
      if (with_fmt && i == fmt_at) begin
        case ($urandom_range(0, 5))
          0: fmt_len = 16;
          1: fmt_len = 18;
          2: fmt_len = 14;
          3: fmt_len = 15;
          4: fmt_len = 17;
          default: fmt_len = $urandom_range(0, 24);
        endcase
        case ($urandom_range(0, 9))
          0: align = '0;
          1, 2, 3, 4, 5: align = 16'($urandom_range(1, 8));
          6: align = 16'hFFFF;
          default: align = 16'($urandom);
        endcase
        put_fmt(fmt_len, align);
      end
      if (i < n_other) begin
        case ($urandom_range(0, 3))
          0: other_tag = 32'h4C49_5354;
          1: other_tag = 32'h6661_6374;
          2: other_tag = 32'h6461_7462;
          default: other_tag = $urandom;
        endcase
        put_chunk(other_tag, $urandom_range(0, 8));
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      case ($urandom_range(0, 7))
        0: size = '0;
        1: size = 32'hFFFF_FFFF;
        2: size = $urandom_range(0, 100);
        default: size = $urandom;
      endcase
      put_data(size);
      put_random($urandom_range(0, 4));
    end
    // some files are cut short at a random point
    if ($urandom_range(0, 4) == 0) trim_file($urandom_range(0, file_q.size() - 1));
  endfunction

  function void make_random_file();
    int kind;
    int pos;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      put_good_file();
    end else if (kind < 88) begin
      put_good_file();
      pos = $urandom_range(0, file_q.size() - 1);
      file_q[pos] ^= 8'(1 << $urandom_range(0, 7));
    end else begin
      put_random($urandom_range(1, 12));
    end
  endfunction

  task send_byte(logic [7:0] b, logic eof);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    file_byte <= b;
    end_of_file <= eof;
    do @(posedge clk); while (full);
    board.note_byte(b, eof);
    bytes_sent++;
  endtask

  task send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
    files_sent++;
  endtask

  task wait_results_drained();
    push <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // receiver holds off while short files pile up behind the result queue
  task stall_receiver_and_fill();
    push <= 1'b0;
    hold_request = 1'b1;
    do @(posedge clk); while (!rx_holding);
    repeat (16) begin
      put_random($urandom_range(1, 6));
      send_file();
    end
    wait_results_drained();
  endtask

  task run_random(int min_bytes, int min_files);
    int first_byte;
    int first_file;
    first_byte = bytes_sent;
    first_file = files_sent;
    while (bytes_sent - first_byte < min_bytes || files_sent - first_file < min_files) begin
      make_random_file();
      send_file();
    end
  endtask

  task run_directed();
    put_tag(32'h5249_4658); put_random(3); send_file();
    // file ends on the last byte of a bad wave tag
    put_tag(TAG_RIFF); put_le32(32'h24); put_tag(32'h5741_5646); send_file();
    put_tag(32'h0000_0000); send_file();
    file_q.push_back(8'h52); file_q.push_back(8'h49); send_file();
    put_tag(TAG_RIFF); put_random(2); send_file();
    put_header(); put_random(2); send_file();
    put_header(); put_fmt(16, 16'd4); put_data(1000); put_random(3); send_file();
    put_header(); put_data(64); send_file();
    put_header(); put_fmt(14, 16'd4); put_data(10); send_file();
    // a later short fmt forgets the align
    put_header(); put_fmt(16, 16'd2); put_fmt(15, 16'd2); put_data(10); send_file();
    put_header(); put_fmt(17, 16'd3); put_chunk(32'h4C49_5354, 0);
    put_chunk(32'h6661_6374, 3);
    put_data(32'hFFFF_FFFF); send_file();
    put_header(); put_fmt(18, 16'hFFFF); put_data(32'hFFFF_FFFF); put_random(2); send_file();
    put_header(); put_fmt(16, 16'd1); put_data(32'hFFFF_FFFF); send_file();
    put_header(); put_fmt(16, 16'd0); put_data(8); send_file();
    put_header(); put_fmt(16, 16'd2); put_data(0); put_random(1); send_file();
    // odd size of all ones needs the full 33-bit skip
    put_header(); put_fmt(16, 16'd4); put_chunk(32'h4A55_4E4B, 32'hFFFF_FFFF); put_random(5);
    send_file();
    put_header(); put_fmt(32'hFFFF_FFFF, 16'd4); put_random(4); send_file();
    put_header(); put_fmt(16, 16'd4); send_file();
    put_header(); put_fmt(16, 16'd4); trim_file(6); send_file();
    put_header(); put_fmt(16, 16'd4); put_data(100); trim_file(2); send_file();
  endtask

  initial begin : receiver
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rx_holding = 1'b1;
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end
      pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      @(posedge clk);
      if (pop && !empty) board.check_result(frame_count, status);
    end
  end

  // ends the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("wav_data_frame_counter_tb failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    board = new();
    tx_idle_pct = 6;
    rx_idle_pct = 82;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(30, 1);
    stall_receiver_and_fill();
    tx_idle_pct = 82;
    rx_idle_pct = 6;
    run_random(30, 1);
    wait_results_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(30, 1);
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("wav_data_frame_counter_tb passed");
    end else begin
      $display("wav_data_frame_counter_tb failed");
    end
    $finish;
  end

endmodule
